// ===== design/lzct_pkg.sv =====
// Package for the zoom command transmitter: shared types, codes and constants.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing else.
`default_nettype none

package lzct_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  BIT_TICKS_RST     = 8'd208;
  localparam logic [7:0]  DELAY_TICKS_RST   = 8'd0;
  localparam logic [7:0]  SHIFT_TICKS_RST   = 8'd26;
  localparam logic [15:0] SILENCE_LIMIT_RST = 16'd500;
  localparam logic [4:0]  SPEED_SCALE_RST   = 5'd8;
  localparam logic [3:0]  EASE_STEP_RST     = 4'd1;

  localparam logic [7:0]  ZOOM_CMD_BYTE = 8'h28;
  localparam logic [3:0]  EASE_MAX      = 4'd8;
  localparam int unsigned LEVEL_MAX     = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_TICKS     = 3'd0,
    REG_DELAY_TICKS   = 3'd1,
    REG_SHIFT_TICKS   = 3'd2,
    REG_SILENCE_LIMIT = 3'd3,
    REG_SPEED_SCALE   = 3'd4,
    REG_EASE_STEP     = 3'd5
  } lzct_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } lzct_state_t;

  typedef struct packed {
    logic step;
    logic clear_pending;
    logic start_byte;
    logic advance_tick;
    logic send_bit;
    logic end_byte;
  } lzct_cmd_t;

  typedef struct packed {
    logic falling_edge;
    logic start_ok;
    logic tick_hit;
    logic last_bit;
  } lzct_stat_t;

endpackage

`default_nettype wire

// ===== design/lzct_if.sv =====
// Valid/ready channel interfaces for input beats, result beats and configuration writes.
// Depends on lzct_pkg for the configuration field widths.
`default_nettype none

interface lzct_in_if;
  logic              valid;
  logic              ready;
  logic              line_level;
  logic              ramp_strobe;
  logic signed [4:0] goal_speed;

  modport source (output valid, output line_level, output ramp_strobe, output goal_speed,
                  input ready);
  modport sink (input valid, input line_level, input ramp_strobe, input goal_speed,
                output ready);
endinterface

interface lzct_out_if;
  logic              valid;
  logic              ready;
  logic              drive_level;
  logic              sending;
  logic              command_pending;
  logic [2:0]        byte_index;
  logic signed [8:0] ramp_speed;
  logic [7:0]        second_byte;

  modport source (output valid, output drive_level, output sending, output command_pending,
                  output byte_index, output ramp_speed, output second_byte, input ready);
  modport sink (input valid, input drive_level, input sending, input command_pending,
                input byte_index, input ramp_speed, input second_byte, output ready);
endinterface

interface lzct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lzct_pkg::CFG_INDEX_W-1:0]  index;
  logic [lzct_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lzct_ctrl.sv =====
// Controller: byte timing state machine and the input/result handshake.
// Depends on lzct_pkg for the state, command and status types.
`default_nettype none

module lzct_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      sending,
  input  wire lzct_pkg::lzct_stat_t stat,
  output lzct_pkg::lzct_cmd_t       cmd
);
  import lzct_pkg::*;

  lzct_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign sending   = (state_r == ST_SEND);

  always_comb begin
    state_nxt = state_r;
    if (step) begin
      case (state_r)
        ST_IDLE: begin
          if (stat.falling_edge && stat.start_ok) state_nxt = ST_SEND;
        end
        ST_SEND: begin
          if (stat.tick_hit && stat.last_bit) state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.step = step;
    if (step) begin
      case (state_r)
        ST_IDLE: begin
          cmd.clear_pending = stat.falling_edge;
          cmd.start_byte    = stat.falling_edge && stat.start_ok;
        end
        ST_SEND: begin
          cmd.advance_tick = 1'b1;
          cmd.send_bit     = stat.tick_hit && !stat.last_bit;
          cmd.end_byte     = stat.tick_hit && stat.last_bit;
        end
        default: cmd = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lzct_datapath.sv =====
// Datapath: configuration registers, bit timer, frame byte shifter and speed ramp.
// Depends on lzct_pkg for constants, register codes and the command/status types.
`default_nettype none

module lzct_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                line_level,
  input  wire logic                                ramp_strobe,
  input  wire logic signed [4:0]                   goal_speed,
  input  wire logic                                cfg_we,
  input  wire logic [lzct_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lzct_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire lzct_pkg::lzct_cmd_t                 cmd,
  output lzct_pkg::lzct_stat_t                     stat,
  output logic                                     drive_level,
  output logic                                     command_pending,
  output logic [2:0]                               byte_index,
  output logic signed [8:0]                        ramp_speed,
  output logic [7:0]                               second_byte
);
  import lzct_pkg::*;

  logic [7:0]  bit_ticks_r, delay_ticks_r, shift_ticks_r;
  logic [15:0] silence_limit_r;
  logic [4:0]  speed_scale_r;
  logic [3:0]  ease_step_r;

  logic              drive_r, drive_nxt;
  logic              prev_line_r;
  logic [3:0]        bit_index_r, bit_index_nxt;
  logic [2:0]        byte_count_r, byte_count_nxt;
  logic [7:0]        tick_r, tick_nxt;
  logic [7:0]        cmp_r, cmp_nxt;
  logic              pending_r, pending_nxt;
  logic [7:0]        first_byte_r, first_byte_nxt;
  logic [7:0]        second_byte_r, second_byte_nxt;
  logic signed [8:0] speed_r, speed_nxt;
  logic [15:0]       silence_r, silence_nxt;

  logic [7:0]        tick_inc;
  logic [7:0]        bit_period;
  logic              pend_mid;
  logic              quiet;
  logic              fire;
  logic [4:0]        scale_eff;
  logic [3:0]        ease_eff;
  logic signed [4:0] goal_c;
  logic signed [9:0] goal_x, scale_x, target, speed_x, two_s, step_mag, speed_new;
  logic              slow;
  logic              neg;
  logic [8:0]        speed_abs;
  logic [8:0]        thresh [1:LEVEL_MAX+1];
  logic [LEVEL_MAX:1] ge_lvl;
  logic              ge_over;
  logic [3:0]        mag;
  logic [2:0]        mag_m1;

  assign tick_inc   = tick_r + 8'd1;
  assign bit_period = bit_ticks_r - delay_ticks_r;

  assign stat.falling_edge = prev_line_r && !line_level;
  assign stat.start_ok     = (byte_count_r != 3'd0) || pending_r;
  assign stat.tick_hit     = (tick_inc == cmp_r);
  assign stat.last_bit     = bit_index_r[3];

  always_comb begin
    tick_nxt       = tick_r;
    cmp_nxt        = cmp_r;
    drive_nxt      = drive_r;
    bit_index_nxt  = bit_index_r;
    byte_count_nxt = byte_count_r;
    if (cmd.advance_tick) tick_nxt = tick_inc;
    if (cmd.start_byte) begin
      tick_nxt = 8'd0;
      cmp_nxt  = bit_period - shift_ticks_r;
    end
    if (cmd.send_bit) begin
      tick_nxt      = 8'd0;
      cmp_nxt       = bit_period;
      bit_index_nxt = bit_index_r + 4'd1;
      if (byte_count_r == 3'd0) drive_nxt = first_byte_r[bit_index_r[2:0]];
      else if (byte_count_r == 3'd1) drive_nxt = second_byte_r[bit_index_r[2:0]];
    end
    if (cmd.end_byte) begin
      tick_nxt       = 8'd0;
      drive_nxt      = 1'b0;
      bit_index_nxt  = 4'd0;
      byte_count_nxt = byte_count_r + 3'd1;
    end
  end

  always_comb begin
    scale_eff = (speed_scale_r == 5'd0) ? 5'd1 : speed_scale_r;
    ease_eff  = (ease_step_r > EASE_MAX) ? EASE_MAX : ease_step_r;
    if (goal_speed > 5'sd8) goal_c = 5'sd8;
    else if (goal_speed < -5'sd8) goal_c = -5'sd8;
    else goal_c = goal_speed;
    goal_x   = 10'(goal_c);
    scale_x  = $signed({5'd0, scale_eff});
    target   = goal_x * scale_x;
    speed_x  = 10'(speed_r);
    two_s    = $signed({4'd0, scale_eff, 1'b0});
    slow     = (speed_x > -two_s) && (speed_x < two_s);
    step_mag = slow ? 10'sd1 : $signed({6'd0, ease_eff});
    if (target > speed_x) speed_new = speed_x + step_mag;
    else if (target < speed_x) speed_new = speed_x - step_mag;
    else speed_new = speed_x;

    neg       = speed_new[9];
    speed_abs = neg ? 9'(-speed_new) : speed_new[8:0];
    for (int k = 1; k <= LEVEL_MAX + 1; k++) begin
      thresh[k] = 9'(k) * {4'd0, scale_eff};
    end
    for (int k = 1; k <= LEVEL_MAX; k++) begin
      ge_lvl[k] = (speed_abs >= thresh[k]);
    end
    ge_over = (speed_abs >= thresh[LEVEL_MAX+1]);
    mag     = 4'($countones(ge_lvl));
    mag_m1  = 3'(mag - 4'd1);
  end

  always_comb begin
    pend_mid        = pending_r && !cmd.clear_pending;
    quiet           = line_level && !pend_mid;
    fire            = cmd.step && ramp_strobe && quiet && (silence_r > silence_limit_r);
    pending_nxt     = pend_mid;
    silence_nxt     = silence_r;
    speed_nxt       = speed_r;
    first_byte_nxt  = first_byte_r;
    second_byte_nxt = second_byte_r;
    if (cmd.step && ramp_strobe) begin
      if (!quiet) silence_nxt = 16'd0;
      else if (fire) silence_nxt = 16'd0;
      else silence_nxt = silence_r + 16'd1;
    end
    if (fire) begin
      speed_nxt = speed_new[8:0];
      if (ge_lvl[1]) begin
        pending_nxt = 1'b1;
        if (!ge_over) begin
          first_byte_nxt  = ZOOM_CMD_BYTE;
          second_byte_nxt = {3'd0, neg, mag_m1, 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r     <= BIT_TICKS_RST;
      delay_ticks_r   <= DELAY_TICKS_RST;
      shift_ticks_r   <= SHIFT_TICKS_RST;
      silence_limit_r <= SILENCE_LIMIT_RST;
      speed_scale_r   <= SPEED_SCALE_RST;
      ease_step_r     <= EASE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_TICKS:     bit_ticks_r     <= cfg_data[7:0];
        REG_DELAY_TICKS:   delay_ticks_r   <= cfg_data[7:0];
        REG_SHIFT_TICKS:   shift_ticks_r   <= cfg_data[7:0];
        REG_SILENCE_LIMIT: silence_limit_r <= cfg_data[15:0];
        REG_SPEED_SCALE:   speed_scale_r   <= cfg_data[4:0];
        REG_EASE_STEP:     ease_step_r     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r       <= 1'b0;
      prev_line_r   <= 1'b1;
      bit_index_r   <= 4'd0;
      byte_count_r  <= 3'd0;
      tick_r        <= 8'd0;
      cmp_r         <= 8'd0;
      pending_r     <= 1'b0;
      first_byte_r  <= 8'd0;
      second_byte_r <= 8'd0;
      speed_r       <= 9'sd0;
      silence_r     <= 16'd0;
    end else if (cmd.step) begin
      drive_r       <= drive_nxt;
      prev_line_r   <= line_level;
      bit_index_r   <= bit_index_nxt;
      byte_count_r  <= byte_count_nxt;
      tick_r        <= tick_nxt;
      cmp_r         <= cmp_nxt;
      pending_r     <= pending_nxt;
      first_byte_r  <= first_byte_nxt;
      second_byte_r <= second_byte_nxt;
      speed_r       <= speed_nxt;
      silence_r     <= silence_nxt;
    end
  end

  assign drive_level     = drive_r;
  assign command_pending = pending_r;
  assign byte_index      = byte_count_r;
  assign ramp_speed      = speed_r;
  assign second_byte     = second_byte_r;

endmodule

`default_nettype wire

// ===== design/lanc_zoom_command_transmitter.sv =====
// Top level of the zoom command transmitter for a single-wire camera control bus.
// Depends on lzct_pkg, the channel interfaces, lzct_ctrl and lzct_datapath.
//
// Usage: every input beat is one timer tick carrying the sampled line level, a ramp
// strobe and the goal zoom speed. Each accepted beat yields exactly one result beat
// with the pin level, the sending flag, the pending mark, the frame byte index, the
// ramped speed and the latched second command byte, all as they stand after that tick.
// Configuration writes go through cfg_chan, which is always ready; write only while
// no result is outstanding.
// Latency: the result beat is valid in the cycle after the input beat is accepted.
// Throughput: one tick per clock cycle while results are taken; all of a tick's work,
// including the speed ramp's level decode, is combinational between state registers.
// Stall: results wait in the output register; while a result waits and the receiver
// holds out_chan.ready low, in_chan.ready is low and the block state is frozen.
// Reset: rst_n is synchronous and active low. It loads the default timing and ramp
// settings, clears the byte timer, the command bytes and the ramp speed, and leaves
// the line tracker at idle high. No result is pending after reset.
`default_nettype none

module lanc_zoom_command_transmitter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lzct_in_if.sink    in_chan,
  lzct_out_if.source out_chan,
  lzct_cfg_if.sink   cfg_chan
);
  import lzct_pkg::*;

  lzct_cmd_t  cmd;
  lzct_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  lzct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .sending   (out_chan.sending),
    .stat      (stat),
    .cmd       (cmd)
  );

  lzct_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_level      (in_chan.line_level),
    .ramp_strobe     (in_chan.ramp_strobe),
    .goal_speed      (in_chan.goal_speed),
    .cfg_we          (cfg_chan.valid),
    .cfg_index       (cfg_chan.index),
    .cfg_data        (cfg_chan.data),
    .cmd             (cmd),
    .stat            (stat),
    .drive_level     (out_chan.drive_level),
    .command_pending (out_chan.command_pending),
    .byte_index      (out_chan.byte_index),
    .ramp_speed      (out_chan.ramp_speed),
    .second_byte     (out_chan.second_byte)
  );

endmodule

`default_nettype wire
